@@ src/aswoc_pkg.sv @@
// shared types and constants for the array sorter
`timescale 1ns / 1ps
package aswoc_pkg;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 12;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;

  localparam logic [1:0] ALG_BUBBLE    = 2'd0;
  localparam logic [1:0] ALG_SELECTION = 2'd1;
  localparam logic [1:0] ALG_INSERTION = 2'd2;
  localparam logic [1:0] ALG_SHELL     = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_WRITE_IN,
    OP_READ_A,
    OP_READ_B,
    OP_WRITE_A,
    OP_WRITE_B
  } dp_op_t;
endpackage

@@ src/array_sorter_with_op_counts_top.sv @@
// top level of the array sorter with operation counts
`timescale 1ns / 1ps
// Collects up to DEPTH signed values (extras dropped, truncated flagged) until
// a beat marked last, sorts them in a one-port element memory with the
// algorithm in cfg_data (0 bubble, 1 selection, 2 insertion, 3 shell), then
// emits the sorted set one beat per element with that run's comparison and
// move counts. Each compare step reads the memory and may write it back.
// Input is taken one beat a cycle only while loading; cfg writes are taken
// only in the load state, not while sorting or emitting.
module array_sorter_with_op_counts_top #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_value,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_sorted_value,
  output logic                out_end_of_set,
  output logic [11:0]         out_comparisons,
  output logic [11:0]         out_moves,
  output logic                out_truncated
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1) + 1;

  logic [1:0] alg_r;
  logic idle;
  aswoc_pkg::dp_op_t op;
  logic [AW-1:0] addr;
  logic wsel_b, inc_cmp, inc_mov, set_ovf;
  logic signed [31:0] a_q, b_q;

  assign cfg_ready = idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alg_r <= aswoc_pkg::ALG_BUBBLE;
    end else if (cfg_valid && cfg_ready) begin
      alg_r <= cfg_data;
    end
  end

  aswoc_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk, .rst_n, .alg(alg_r), .in_valid, .in_last, .in_stall,
    .out_valid, .out_stall, .out_end(out_end_of_set), .idle, .op, .addr,
    .wsel_b, .inc_cmp, .inc_mov, .set_ovf, .a_q, .b_q
  );

  aswoc_datapath #(.DEPTH(DEPTH), .AW(AW)) u_dp (
    .clk, .rst_n, .op, .addr, .wsel_b, .in_data(in_value), .inc_cmp,
    .inc_mov, .set_ovf, .a_q, .b_q, .cmp_q(out_comparisons),
    .mov_q(out_moves), .ovf_q(out_truncated)
  );

  assign out_sorted_value = a_q;
endmodule

@@ src/aswoc_datapath.sv @@
// element memory, two registers and run counters of the array sorter
`timescale 1ns / 1ps
module aswoc_datapath #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  aswoc_pkg::dp_op_t                  op,
  input  logic [AW-1:0]                      addr,
  input  logic                               wsel_b,
  input  logic signed [aswoc_pkg::DATA_W-1:0] in_data,
  input  logic                               inc_cmp,
  input  logic                               inc_mov,
  input  logic                               set_ovf,
  output logic signed [aswoc_pkg::DATA_W-1:0] a_q,
  output logic signed [aswoc_pkg::DATA_W-1:0] b_q,
  output logic [aswoc_pkg::COUNT_W-1:0]       cmp_q,
  output logic [aswoc_pkg::COUNT_W-1:0]       mov_q,
  output logic                               ovf_q
);
  logic signed [aswoc_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [aswoc_pkg::DATA_W-1:0] a_r, b_r;
  logic [aswoc_pkg::COUNT_W-1:0] cmp_r, mov_r;
  logic ovf_r;

  always_ff @(posedge clk) begin
    if (op == aswoc_pkg::OP_WRITE_IN) begin
      mem[addr] <= in_data;
    end else if (op == aswoc_pkg::OP_WRITE_A) begin
      mem[addr] <= wsel_b ? b_r : a_r;
    end
    if (op == aswoc_pkg::OP_READ_A) begin
      a_r <= mem[addr];
    end
    if (op == aswoc_pkg::OP_READ_B) begin
      b_r <= mem[addr];
    end
    if (op == aswoc_pkg::OP_WRITE_B) begin
      b_r <= a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || op == aswoc_pkg::OP_CLEAR) begin
      cmp_r <= '0;
      mov_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      if (inc_cmp && cmp_r != aswoc_pkg::COUNT_MAX) begin
        cmp_r <= cmp_r + 1'b1;
      end
      if (inc_mov && mov_r != aswoc_pkg::COUNT_MAX) begin
        mov_r <= mov_r + 1'b1;
      end
      if (set_ovf) begin
        ovf_r <= 1'b1;
      end
    end
  end

  assign a_q   = a_r;
  assign b_q   = b_r;
  assign cmp_q = cmp_r;
  assign mov_q = mov_r;
  assign ovf_q = ovf_r;
endmodule

@@ src/aswoc_ctrl.sv @@
// sequencer for load, sort and drain of the array sorter
`timescale 1ns / 1ps
module aswoc_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [1:0]                          alg,
  input  logic                                in_valid,
  input  logic                                in_last,
  output logic                                in_stall,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_end,
  output logic                                idle,
  output aswoc_pkg::dp_op_t                   op,
  output logic [AW-1:0]                       addr,
  output logic                                wsel_b,
  output logic                                inc_cmp,
  output logic                                inc_mov,
  output logic                                set_ovf,
  input  logic signed [aswoc_pkg::DATA_W-1:0] a_q,
  input  logic signed [aswoc_pkg::DATA_W-1:0] b_q
);
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_RDA   = 4'd2;
  localparam logic [3:0] S_RDB   = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_WRA   = 4'd5;
  localparam logic [3:0] S_WRB   = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_GAP   = 4'd8;
  localparam logic [3:0] S_OUTRD = 4'd9;
  localparam logic [3:0] S_OUTW  = 4'd10;
  localparam logic [3:0] S_OUTV  = 4'd11;
  localparam logic [3:0] S_CLR   = 4'd12;
  localparam logic [3:0] S_SWP   = 4'd13;

  logic [3:0]    st_r, st_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] i_r, i_nxt;   // outer index
  logic [CW-1:0] j_r, j_nxt;   // inner index
  logic [CW-1:0] m_r, m_nxt;   // selection minimum / shell descent flag
  logic [CW+1:0] h_r, h_nxt;   // gap
  logic [CW+1:0] h3;
  logic [CW+12:0] h_prod;
  logic [CW+1:0] h_third;
  logic          gt_ab;

  // a holds the upper/key element, b the compared element
  assign gt_ab = a_q > b_q;
  assign h3    = CW'(0) + (h_r << 1) + h_r + 1'b1;
  // divide by three via reciprocal, exact for gaps below 2048
  assign h_prod  = (CW+13)'(h_r) * (CW+13)'(683);
  assign h_third = h_prod[CW+12:11];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD;
      n_r  <= '0;
      i_r  <= '0;
      j_r  <= '0;
      m_r  <= '0;
      h_r  <= '0;
    end else begin
      st_r <= st_nxt;
      n_r  <= n_nxt;
      i_r  <= i_nxt;
      j_r  <= j_nxt;
      m_r  <= m_nxt;
      h_r  <= h_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    n_nxt    = n_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    m_nxt    = m_r;
    h_nxt    = h_r;
    op       = aswoc_pkg::OP_NONE;
    addr     = '0;
    wsel_b   = 1'b0;
    inc_cmp  = 1'b0;
    inc_mov  = 1'b0;
    set_ovf  = 1'b0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    out_end  = (i_r + 1'b1 == n_r);
    idle     = (st_r == S_LOAD);
    case (st_r)
      S_LOAD: begin
        in_stall = 1'b0;
        addr = n_r[AW-1:0];
        if (in_valid) begin
          if (n_r < CW'(DEPTH)) begin
            op = aswoc_pkg::OP_WRITE_IN;
            n_nxt = n_r + 1'b1;
          end else begin
            set_ovf = 1'b1;
          end
          if (in_last) begin
            st_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        i_nxt = '0;
        m_nxt = '0;
        case (alg)
          aswoc_pkg::ALG_BUBBLE: begin
            i_nxt = CW'(1);  // pass number
            j_nxt = '0;
            st_nxt = (n_r > CW'(1)) ? S_RDA : S_OUTRD;
          end
          aswoc_pkg::ALG_SELECTION: begin
            i_nxt = '0;
            m_nxt = '0;
            j_nxt = CW'(1);
            st_nxt = (n_r > CW'(1)) ? S_RDA : S_OUTRD;
          end
          aswoc_pkg::ALG_INSERTION: begin
            h_nxt = (CW+2)'(1);
            i_nxt = CW'(1);
            j_nxt = CW'(1);
            st_nxt = (n_r > CW'(1)) ? S_RDA : S_OUTRD;
          end
          default: begin
            h_nxt = (CW+2)'(1);
            st_nxt = S_GAP;
          end
        endcase
        if (st_nxt == S_OUTRD) begin
          i_nxt = '0;
        end
      end
      S_GAP: begin
        // grow knuth gap until it reaches n, then step down
        if (m_r == '0 && h_r < (CW+2)'(n_r)) begin
          h_nxt = h3;
        end else begin
          h_nxt = h_third;
          i_nxt = h_nxt[CW-1:0];
          j_nxt = h_nxt[CW-1:0];
          if (h_nxt == '0) begin
            i_nxt = '0;
            st_nxt = S_OUTRD;
          end else if ((CW+2)'(h_nxt) < (CW+2)'(n_r)) begin
            st_nxt = S_RDA;
          end else begin
            st_nxt = S_NEXT;
            h_nxt = h_nxt;
          end
          m_nxt = CW'(1);  // marks descent mode
        end
      end
      S_RDA: begin
        op = aswoc_pkg::OP_READ_A;
        case (alg)
          aswoc_pkg::ALG_BUBBLE:    addr = j_r[AW-1:0] + 1'b1;
          aswoc_pkg::ALG_SELECTION: addr = j_r[AW-1:0];
          default: begin
            addr = i_r[AW-1:0];
            if (alg == aswoc_pkg::ALG_SHELL) begin
              inc_cmp = 1'b1;
            end else begin
              inc_cmp = 1'b1;
            end
          end
        endcase
        st_nxt = S_RDB;
      end
      S_RDB: begin
        op = aswoc_pkg::OP_READ_B;
        case (alg)
          aswoc_pkg::ALG_BUBBLE:    addr = j_r[AW-1:0];
          aswoc_pkg::ALG_SELECTION: addr = m_r[AW-1:0];
          default: addr = j_r[AW-1:0] - h_r[AW-1:0];
        endcase
        st_nxt = S_CMP;
      end
      S_CMP: begin
        case (alg)
          aswoc_pkg::ALG_BUBBLE: begin
            inc_cmp = 1'b1;
            if (b_q > a_q) begin
              st_nxt = S_WRA;
            end else begin
              st_nxt = S_NEXT;
            end
          end
          aswoc_pkg::ALG_SELECTION: begin
            inc_cmp = 1'b1;
            if (b_q > a_q) begin
              // b keeps the current minimum
              op = aswoc_pkg::OP_WRITE_B;
              m_nxt = j_r;
            end
            st_nxt = S_NEXT;
          end
          aswoc_pkg::ALG_INSERTION: begin
            // a is key, b is store[j-1]
            if (gt_ab == 1'b0 && b_q > a_q) begin
              st_nxt = S_WRB;
            end else begin
              st_nxt = S_SWP;
            end
          end
          default: begin
            if (!gt_ab) begin
              st_nxt = S_WRB;
            end else begin
              st_nxt = S_SWP;
            end
          end
        endcase
      end
      S_WRA: begin
        // bubble swap: store[j] <= a (upper), store[j+1] <= b
        op = aswoc_pkg::OP_WRITE_A;
        addr = j_r[AW-1:0];
        st_nxt = S_WRB;
      end
      S_WRB: begin
        op = aswoc_pkg::OP_WRITE_A;
        wsel_b = 1'b1;
        inc_mov = 1'b1;
        if (alg == aswoc_pkg::ALG_BUBBLE) begin
          addr = j_r[AW-1:0] + 1'b1;
          st_nxt = S_NEXT;
        end else if (alg == aswoc_pkg::ALG_SELECTION) begin
          addr = i_r[AW-1:0];
          st_nxt = S_SWP;
        end else begin
          // shift store[j-h] up to store[j], then step down
          addr = j_r[AW-1:0];
          j_nxt = j_r - h_r[CW-1:0];
          if (j_nxt >= h_r[CW-1:0]) begin
            st_nxt = S_RDB;
          end else begin
            st_nxt = S_SWP;
          end
        end
      end
      S_SWP: begin
        op = aswoc_pkg::OP_WRITE_A;
        if (alg == aswoc_pkg::ALG_SELECTION) begin
          // write old store[i] (in a after the read of i in S_CLR) to minimum slot
          addr = m_r[AW-1:0];
          wsel_b = 1'b0;
          j_nxt = i_r + 2'd2;
          i_nxt = i_r + 1'b1;
          m_nxt = i_r + 1'b1;
          st_nxt = (i_r + 2'd2 < n_r) ? S_RDA : S_OUTRD;
          if (st_nxt == S_OUTRD) begin
            i_nxt = '0;
          end
        end else begin
          // place key
          addr = j_r[AW-1:0];
          st_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        case (alg)
          aswoc_pkg::ALG_BUBBLE: begin
            if (j_r + 2'd2 < n_r) begin
              j_nxt = j_r + 1'b1;
              st_nxt = S_RDA;
            end else if (i_r + 1'b1 < n_r) begin
              i_nxt = i_r + 1'b1;
              j_nxt = '0;
              st_nxt = S_RDA;
            end else begin
              i_nxt = '0;
              st_nxt = S_OUTRD;
            end
          end
          aswoc_pkg::ALG_SELECTION: begin
            if (j_r + 1'b1 < n_r) begin
              j_nxt = j_r + 1'b1;
              st_nxt = S_RDA;
            end else if (m_r != i_r) begin
              // read store[i] into a (b already holds store[m]), then swap
              st_nxt = S_CLR;
            end else begin
              j_nxt = i_r + 2'd2;
              i_nxt = i_r + 1'b1;
              m_nxt = i_r + 1'b1;
              st_nxt = (i_r + 2'd2 < n_r) ? S_RDA : S_OUTRD;
              if (st_nxt == S_OUTRD) begin
                i_nxt = '0;
              end
            end
          end
          default: begin
            if (i_r + 1'b1 < n_r) begin
              i_nxt = i_r + 1'b1;
              j_nxt = i_r + 1'b1;
              st_nxt = S_RDA;
            end else if (alg == aswoc_pkg::ALG_SHELL) begin
              st_nxt = S_GAP;
            end else begin
              i_nxt = '0;
              st_nxt = S_OUTRD;
            end
          end
        endcase
      end
      S_CLR: begin
        // selection swap: a <= store[i], b holds store[m]
        op = aswoc_pkg::OP_READ_A;
        addr = i_r[AW-1:0];
        st_nxt = S_WRB;
      end
      S_OUTRD: begin
        op = aswoc_pkg::OP_READ_A;
        addr = i_r[AW-1:0];
        st_nxt = (n_r == '0) ? S_OUTW : S_OUTV;
      end
      S_OUTV: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (out_end) begin
            st_nxt = S_OUTW;
          end else begin
            i_nxt = i_r + 1'b1;
            st_nxt = S_OUTRD;
          end
        end
      end
      S_OUTW: begin
        op = aswoc_pkg::OP_CLEAR;
        n_nxt = '0;
        st_nxt = S_LOAD;
      end
      default: st_nxt = S_LOAD;
    endcase
  end
endmodule

@@ src/aswoc_checker.sv @@
// port-level checks for the array sorter
`timescale 1ns / 1ps
module aswoc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_end_of_set,
  input logic [31:0] out_sorted_value,
  input logic        cfg_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sorted_value))
    else $error("output beat changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during drain");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !out_valid)
    else $error("config open during output");
  a_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_end_of_set |=> !out_valid)
    else $error("beat after end of set");
endmodule

bind array_sorter_with_op_counts_top aswoc_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall,
  .out_end_of_set, .out_sorted_value, .cfg_ready
);

@@ dv/tb_array_sorter_with_op_counts_top.sv @@
// self-checking testbench for the array sorter with operation counts
`timescale 1ns / 1ps
module tb_array_sorter_with_op_counts_top;
  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               eos;
    logic [11:0]        cmps;
    logic [11:0]        mvs;
    logic               trunc;
  } sorted_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = aswoc_pkg::ALG_BUBBLE;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_value = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_sorted_value;
  logic out_end_of_set;
  logic [11:0] out_comparisons;
  logic [11:0] out_moves;
  logic out_truncated;

  array_sorter_with_op_counts_top #(.DEPTH(DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_value(in_value), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sorted_value(out_sorted_value), .out_end_of_set(out_end_of_set),
    .out_comparisons(out_comparisons), .out_moves(out_moves),
    .out_truncated(out_truncated)
  );

  always #5 clk = ~clk;

  in_beat_t     pending_beats[$];
  sorted_beat_t expected_sorted[$];
  logic signed [31:0] held_vals[DEPTH];
  int unsigned held_count = 0;
  logic        held_overflow = 1'b0;
  logic [1:0]  cur_alg = aswoc_pkg::ALG_BUBBLE;
  logic        in_acc = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int beats_checked = 0;
  int sets_sorted = 0;
  int cycle_count = 0;

  function automatic void bump12(ref logic [11:0] c);
    if (c != aswoc_pkg::COUNT_MAX) c = c + 12'd1;
  endfunction

  // sort the held set and queue its output beats
  function automatic void sort_and_predict();
    logic signed [31:0] a[DEPTH];
    logic signed [31:0] key, t;
    logic [11:0] cmps, mvs;
    int n, m, j, h;
    sorted_beat_t b;
    n = held_count;
    cmps = '0;
    mvs = '0;
    for (int k = 0; k < DEPTH; k++) a[k] = held_vals[k];
    case (cur_alg)
      aswoc_pkg::ALG_BUBBLE: begin
        for (int p = 1; p < n; p++)
          for (int i = 0; i + 1 < n; i++) begin
            if (a[i] > a[i+1]) begin
              t = a[i]; a[i] = a[i+1]; a[i+1] = t; bump12(mvs);
            end
            bump12(cmps);
          end
      end
      aswoc_pkg::ALG_SELECTION: begin
        for (int jj = 0; jj + 1 < n; jj++) begin
          m = jj;
          for (int i = jj + 1; i < n; i++) begin
            if (a[m] > a[i]) m = i;
            bump12(cmps);
          end
          if (m != jj) begin
            t = a[jj]; a[jj] = a[m]; a[m] = t; bump12(mvs);
          end
        end
      end
      aswoc_pkg::ALG_INSERTION: begin
        for (int i = 1; i < n; i++) begin
          key = a[i];
          j = i;
          bump12(cmps);
          while (j > 0 && a[j-1] > key) begin
            a[j] = a[j-1]; bump12(mvs); j--;
          end
          a[j] = key;
        end
      end
      default: begin
        h = 1;
        while (h < n) h = 3 * h + 1;
        while (h > 0) begin
          for (int i = h; i < n; i++) begin
            key = a[i];
            j = i;
            bump12(cmps);
            while (j >= h && !(key > a[j-h])) begin
              a[j] = a[j-h]; j -= h; bump12(mvs);
            end
            a[j] = key;
          end
          h = h / 3;
        end
      end
    endcase
    for (int k = 0; k < n; k++) begin
      b.value = a[k];
      b.eos = (k + 1 == n);
      b.cmps = cmps;
      b.mvs = mvs;
      b.trunc = held_overflow;
      expected_sorted.push_back(b);
    end
    held_count = 0;
    held_overflow = 1'b0;
    sets_sorted++;
  endfunction

  function automatic void accept_beat(in_beat_t b);
    if (held_count < DEPTH) begin
      held_vals[held_count] = b.value;
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (b.last) sort_and_predict();
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000 + $urandom_range(0, 3);
      1: return 32'sh7fff_ffff - $urandom_range(0, 3);
      2: return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    if (in_acc) begin
      void'(pending_beats.pop_front());
    end
    if (pending_beats.size() != 0 &&
        ((in_valid && !in_acc) || $urandom_range(0, 99) >= send_idle_pct)) begin
      in_valid <= 1'b1;
      in_value <= pending_beats[0].value;
      in_last <= pending_beats[0].last;
    end else begin
      in_valid <= 1'b0;
    end
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // long receiver hold countdown
  always @(negedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // input side model update and output monitor
  always @(posedge clk) begin
    sorted_beat_t exp_b;
    in_acc <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (in_valid && !in_stall) accept_beat('{value: in_value, last: in_last});
      if (cfg_valid && cfg_ready) cur_alg = cfg_data;
      if (out_valid && !out_stall) begin
        if (expected_sorted.size() == 0) begin
          $display("%0t: unexpected beat value %0d", $time, out_sorted_value);
          errors++;
        end else begin
          exp_b = expected_sorted.pop_front();
          beats_checked++;
          if (out_sorted_value !== exp_b.value || out_end_of_set !== exp_b.eos ||
              out_comparisons !== exp_b.cmps || out_moves !== exp_b.mvs ||
              out_truncated !== exp_b.trunc) begin
            $display("%0t: mismatch expected val=%0d eos=%0b cmp=%0d mv=%0d tr=%0b",
                     $time, exp_b.value, exp_b.eos, exp_b.cmps, exp_b.mvs, exp_b.trunc);
            $display("%0t:          actual val=%0d eos=%0b cmp=%0d mv=%0d tr=%0b",
                     $time, out_sorted_value, out_end_of_set, out_comparisons,
                     out_moves, out_truncated);
            errors++;
          end
        end
      end
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_array_sorter_with_op_counts_top: FAIL");
        $finish;
      end
    end
  end

  task automatic add_set(input int n, input logic [1:0] kind);
    in_beat_t b;
    for (int k = 0; k < n; k++) begin
      case (kind)
        2'd0: b.value = rand_value();
        2'd1: b.value = k - 8;
        2'd2: b.value = 8 - k;
        default: b.value = $signed($urandom_range(0, 2));
      endcase
      b.last = (k == n - 1);
      pending_beats.push_back(b);
    end
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || expected_sorted.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_alg(input logic [1:0] alg);
    @(negedge clk);
    cfg_data <= alg;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0: n = 1;
        1: n = DEPTH;
        2: n = DEPTH + $urandom_range(1, 4);
        default: n = $urandom_range(2, 10);
      endcase
      add_set(n, 2'($urandom_range(0, 3)));
      sent += n;
    end
  endtask

  initial begin
    in_beat_t b;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int alg = 0; alg < 4; alg++) begin
      write_alg(alg[1:0]);
      // directed: single element, extremes, reverse order, duplicates, overflow
      b.value = 32'sh8000_0000; b.last = 1'b1; pending_beats.push_back(b);
      b.value = 32'sh7fff_ffff; b.last = 1'b0; pending_beats.push_back(b);
      b.value = 32'sh8000_0000; b.last = 1'b0; pending_beats.push_back(b);
      b.value = -1;             b.last = 1'b0; pending_beats.push_back(b);
      b.value = 0;              b.last = 1'b1; pending_beats.push_back(b);
      add_set(DEPTH, 2'd2);
      add_set(4, 2'd3);
      add_set(DEPTH + 2, 2'd0);
      drain();
    end
    for (int ph = 0; ph < 4; ph++) begin
      write_alg(2'($urandom_range(0, 3)));
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      random_phase(35);
      if (ph == 0) hold_cycles = 3000;
      drain();
    end
    send_idle_pct = 10;
    recv_stall_pct = 10;
    write_alg(aswoc_pkg::ALG_SHELL);
    random_phase(20);
    drain();
    write_alg(aswoc_pkg::ALG_BUBBLE);
    random_phase(20);
    drain();
    $display("covered %0d sorted sets and %0d checked output beats over all four algorithms",
             sets_sorted, beats_checked);
    $display("with overflowed sets, extreme values, duplicates and idle/stall mixes");
    if (errors == 0)
      $display("tb_array_sorter_with_op_counts_top: PASS");
    else
      $display("tb_array_sorter_with_op_counts_top: FAIL");
    $finish;
  end
endmodule
